[sv/spcd_pkg.sv]
// spcd_pkg: shared types and constants of the serial power command decoder
// no dependencies; used by serial_power_command_decoder, spcd_status_check and the testbench
`default_nettype none

package spcd_pkg;

    // event codes reported with a status item
    typedef enum logic [1:0] {
        EV_OFF     = 2'd0,
        EV_ON      = 2'd1,
        EV_TIMEOUT = 2'd2
    } spcd_ev_t;

    // item kinds on the command channel
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } spcd_kind_t;

    localparam int unsigned CMD_LEN         = 17;
    localparam int unsigned PREFIX_LEN      = 14;
    localparam int unsigned START_FRAME_LEN = 19;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [7:0] BYTE_SYNC = 8'h7c;
    localparam logic [7:0] BYTE_00   = 8'h00;
    localparam logic [7:0] BYTE_01   = 8'h01;
    localparam logic [7:0] BYTE_11   = 8'h11;

    // fixed command prefix
    localparam logic [7:0] CMD_PREFIX [0:PREFIX_LEN-1] = '{
        8'h7c, 8'h02, 8'h02, 8'h00, 8'h01, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // fixed start frame
    localparam logic [7:0] START_FRAME [0:START_FRAME_LEN-1] = '{
        8'h7c, 8'h02, 8'h01, 8'h00, 8'h0c, 8'h41, 8'h31, 8'h31, 8'h38, 8'h30,
        8'h31, 8'h30, 8'h31, 8'h30, 8'h30, 8'h30, 8'h31, 8'h77, 8'h7c
    };

endpackage

`default_nettype wire

[sv/spcd_cmd_if.sv]
// spcd_cmd_if: command channel (received byte or timer tick) with valid/ready
// no dependencies
`default_nettype none

interface spcd_cmd_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/spcd_status_if.sv]
// spcd_status_if: status channel (event and power state) with valid/ready
// no dependencies
`default_nettype none

interface spcd_status_if;
    logic       valid;
    logic       ready;
    logic       event_valid;
    logic [1:0] event_code;
    logic       power_on;

    modport source (output valid, output event_valid, output event_code,
                    output power_on, input ready);
    modport sink   (input valid, input event_valid, input event_code,
                    input power_on, output ready);
endinterface

`default_nettype wire

[sv/spcd_cfg_if.sv]
// spcd_cfg_if: configuration write channel carrying the timeout limit
// no dependencies
`default_nettype none

interface spcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/serial_power_command_decoder.sv]
// serial_power_command_decoder: frame matcher for serial power commands
// depends on spcd_pkg, spcd_cmd_if, spcd_status_if, spcd_cfg_if
//
//   channel | direction | payload                          | handshake
//   --------+-----------+----------------------------------+------------
//   cmd     | sink      | kind, rx_byte                    | valid/ready
//   status  | source    | event_valid, event_code, power_on| valid/ready
//   cfg     | sink      | data (timeout_ticks)             | valid/ready
//
// one status item per command item: an accepted item passes through the input
// register and then the result register, which drives status; one item per
// cycle sustained while status is taken without a stall
// reset clears the byte count, tick count, timer flag and power state, and sets the
// timeout limit to 1000 ticks; the frame store is not cleared
// a stalled status item holds the result register; the input register still
// takes one more item, then cmd.ready drops until status is taken
`default_nettype none

module serial_power_command_decoder #(
    parameter int unsigned STORE_DEPTH = 19
) (
    input  wire           clk,
    input  wire           rst_n,
    spcd_cmd_if.sink      cmd,
    spcd_status_if.source status,
    spcd_cfg_if.sink      cfg
);
    import spcd_pkg::*;

    // count holds 0..STORE_DEPTH, store index 0..STORE_DEPTH-1
    localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(STORE_DEPTH);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [15:0] timeout_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            timeout_reg <= cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    spcd_kind_t in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;   // result register can take a new result
    logic       proc;      // registered item is decoded this cycle

    assign advance   = !out_valid_reg || status.ready;
    assign proc      = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_kind_reg <= spcd_kind_t'(cmd.kind);
            in_byte_reg <= cmd.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // decoder state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [15:0]      tick_reg;
    logic [15:0]      tick_next;
    logic             run_reg;
    logic             run_next;
    logic             power_reg;
    logic             power_next;
    logic [7:0]       store_reg [0:STORE_DEPTH-1];

    logic             ev_hit;
    spcd_ev_t         ev_code;

    // byte write into the store
    logic             is_byte;
    logic             store_wr;
    logic [CNT_W-1:0] cnt_app;
    logic [15:0]      tick_inc;

    assign is_byte  = (in_kind_reg == KIND_BYTE);
    assign store_wr = is_byte && (cnt_reg < CNT_W'(STORE_DEPTH));
    assign cnt_app  = store_wr ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign tick_inc = tick_reg + 16'd1;

    // store contents as they stand after this byte is written
    logic [7:0] eff [0:START_FRAME_LEN-1];
    logic [START_FRAME_LEN-1:0] start_eq;
    logic [PREFIX_LEN-1:0]      prefix_eq;

    for (genvar i = 0; i < START_FRAME_LEN; i++)
    begin : g_eff
        assign eff[i]      = (store_wr && cnt_reg == CNT_W'(i)) ? in_byte_reg
                                                                : store_reg[i];
        assign start_eq[i] = (eff[i] == START_FRAME[i]);
    end

    for (genvar i = 0; i < PREFIX_LEN; i++)
    begin : g_prefix
        assign prefix_eq[i] = (eff[i] == CMD_PREFIX[i]);
    end

    logic start_hit;
    logic prefix_hit;
    logic on_tail;
    logic off_tail;

    assign start_hit  = &start_eq;
    assign prefix_hit = &prefix_eq;
    // tail sits right after the prefix
    assign on_tail  = (eff[PREFIX_LEN]     == BYTE_00) &&
                      (eff[PREFIX_LEN + 1] == BYTE_01) &&
                      (eff[PREFIX_LEN + 2] == BYTE_SYNC);
    assign off_tail = (eff[PREFIX_LEN]     == BYTE_01) &&
                      (eff[PREFIX_LEN + 1] == BYTE_11) &&
                      (eff[PREFIX_LEN + 2] == BYTE_SYNC);

    always_comb
    begin
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        run_next   = run_reg;
        power_next = power_reg;
        ev_hit     = 1'b0;
        ev_code    = EV_OFF;

        if (is_byte)
        begin
            cnt_next  = cnt_app;
            tick_next = 16'd0;
            run_next  = 1'b1;
            priority if (cnt_app >= CNT_W'(START_FRAME_LEN))
            begin
                // full start frame length: always empty the store
                cnt_next = '0;
                if (start_hit)
                begin
                    power_next = 1'b1;
                    run_next   = 1'b0;
                    ev_hit     = 1'b1;
                    ev_code    = EV_ON;
                end
            end
            else if (cnt_app >= CNT_W'(CMD_LEN) && prefix_hit && on_tail)
            begin
                cnt_next   = '0;
                power_next = 1'b1;
                run_next   = 1'b0;
                ev_hit     = 1'b1;
                ev_code    = EV_ON;
            end
            else if (cnt_app >= CNT_W'(CMD_LEN) && prefix_hit && off_tail)
            begin
                cnt_next   = '0;
                power_next = 1'b0;
                run_next   = 1'b0;
                ev_hit     = 1'b1;
                ev_code    = EV_OFF;
            end
            else
            begin
                // partial frame or mismatch: bytes stay held
            end
        end
        else if (run_reg)
        begin
            tick_next = tick_inc;
            if (tick_inc == timeout_reg)
            begin
                cnt_next = '0;
                run_next = 1'b0;
                ev_hit   = 1'b1;
                ev_code  = EV_TIMEOUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            tick_reg  <= '0;
            run_reg   <= 1'b0;
            power_reg <= 1'b0;
        end
        else if (proc)
        begin
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
            run_reg   <= run_next;
            power_reg <= power_next;
        end
    end

    // frame store, written at the current count
    always_ff @(posedge clk)
    begin
        if (proc && store_wr)
        begin
            store_reg[cnt_reg[IDX_W-1:0]] <= in_byte_reg;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic     ev_valid_reg;
    spcd_ev_t ev_code_reg;
    logic     power_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            ev_valid_reg  <= ev_hit;
            ev_code_reg   <= ev_code;
            power_out_reg <= power_next;
        end
    end

    assign status.valid       = out_valid_reg;
    assign status.event_valid = ev_valid_reg;
    assign status.event_code  = ev_code_reg;
    assign status.power_on    = power_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // the store is emptied at the start frame length, never held beyond it
    a_cnt_bound : assert property (
        @(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(START_FRAME_LEN)
    ) else $error("byte count beyond start frame length");

    // a timeout stops the timer and empties the store
    a_timeout_clears : assert property (
        @(posedge clk) disable iff (!rst_n)
        (proc && ev_hit && ev_code == EV_TIMEOUT) |=> (!run_reg && cnt_reg == '0)
    ) else $error("timeout left timer running or bytes held");

    // power events agree with the reported power state
    a_event_power : assert property (
        @(posedge clk) disable iff (!rst_n)
        (status.valid && status.event_valid && ev_code_reg != EV_TIMEOUT)
            |-> (status.power_on == (ev_code_reg == EV_ON))
    ) else $error("power event disagrees with power state");

    // an item waiting in the input register is not dropped on a stall
    a_hold_input : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg
    ) else $error("input item lost while result stalled");

endmodule

`default_nettype wire

[tb/spcd_status_check.sv]
// spcd_status_check: watches the cmd, cfg and status channels of the serial power
// command decoder, predicts every status item and compares it with the block
// depends on spcd_pkg
`default_nettype none

module spcd_status_check #(
    parameter int unsigned STORE_DEPTH = 19
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cmd_valid,
    input  wire         cmd_ready,
    input  wire         cmd_kind,
    input  wire  [7:0]  cmd_rx_byte,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire  [15:0] cfg_data,
    input  wire         st_valid,
    input  wire         st_ready,
    input  wire         st_event_valid,
    input  wire  [1:0]  st_event_code,
    input  wire         st_power_on,
    output int          fail_count,
    output int          pending,
    output int          item_count,
    output int          on_count,
    output int          off_count,
    output int          timeout_count
);
    import spcd_pkg::*;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_code;
        logic       power_on;
    } status_t;

    // shadow copy of the decoder state
    logic [4:0]  held;
    logic [7:0]  frame [0:31];
    logic [15:0] ticks;
    logic        timing;
    logic        power;
    logic [15:0] limit;

    status_t expected_status [$];
    status_t want;
    int      mismatches;

    // advance the shadow state by one item and return the status it causes
    function automatic status_t step_decoder(input logic kind, input logic [7:0] data);
        status_t r;
        logic    start_ok;
        logic    prefix_ok;
        logic    hit_on;
        logic    hit_off;
        int      i;
        r = '0;
        if (kind == KIND_BYTE) begin
            if (held < STORE_DEPTH) begin
                frame[held] = data;
                held = held + 5'd1;
            end
            ticks  = '0;
            timing = 1'b1;
            if (held >= START_FRAME_LEN) begin
                held = '0;
                start_ok = 1'b1;
                for (i = 0; i < START_FRAME_LEN; i++)
                    if (frame[i] != START_FRAME[i])
                        start_ok = 1'b0;
                if (start_ok) begin
                    power  = 1'b1;
                    timing = 1'b0;
                    r.event_valid = 1'b1;
                    r.event_code  = EV_ON;
                end
            end else if (held >= CMD_LEN) begin
                prefix_ok = 1'b1;
                for (i = 0; i < PREFIX_LEN; i++)
                    if (frame[i] != CMD_PREFIX[i])
                        prefix_ok = 1'b0;
                hit_on  = prefix_ok && frame[CMD_LEN-3] == BYTE_00
                          && frame[CMD_LEN-2] == BYTE_01 && frame[CMD_LEN-1] == BYTE_SYNC;
                hit_off = prefix_ok && frame[CMD_LEN-3] == BYTE_01
                          && frame[CMD_LEN-2] == BYTE_11 && frame[CMD_LEN-1] == BYTE_SYNC;
                if (hit_on || hit_off) begin
                    held   = '0;
                    power  = hit_on;
                    timing = 1'b0;
                    r.event_valid = 1'b1;
                    r.event_code  = hit_on ? EV_ON : EV_OFF;
                end
            end
        end else if (timing) begin
            ticks = ticks + 16'd1;
            if (ticks == limit) begin
                held   = '0;
                timing = 1'b0;
                r.event_valid = 1'b1;
                r.event_code  = EV_TIMEOUT;
            end
        end
        r.power_on = power;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held   = '0;
            ticks  = '0;
            timing = 1'b0;
            power  = 1'b0;
            limit  = TIMEOUT_RESET;
            for (int i = 0; i < 32; i++)
                frame[i] = '0;
            expected_status.delete();
            pending       <= 0;
            fail_count    = 0;
            mismatches    = 0;
            item_count    = 0;
            on_count      = 0;
            off_count     = 0;
            timeout_count = 0;
        end else begin
            if (st_valid && st_ready) begin
                if (expected_status.size() == 0) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"status item with nothing expected: ",
                                  "valid=%0d code=%0d power=%0d"},
                                 st_event_valid, st_event_code, st_power_on);
                end else begin
                    want = expected_status.pop_front();
                    if (st_event_valid !== want.event_valid
                        || st_event_code !== want.event_code
                        || st_power_on !== want.power_on) begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"status mismatch: expected valid=%0d code=%0d ",
                                      "power=%0d, got valid=%0d code=%0d power=%0d"},
                                     want.event_valid, want.event_code, want.power_on,
                                     st_event_valid, st_event_code, st_power_on);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (cmd_valid && cmd_ready) begin
                want = step_decoder(cmd_kind, cmd_rx_byte);
                expected_status.push_back(want);
                item_count++;
                if (want.event_valid) begin
                    if (want.event_code == EV_ON)
                        on_count++;
                    else if (want.event_code == EV_OFF)
                        off_count++;
                    else
                        timeout_count++;
                end
            end
            pending <= expected_status.size();
        end
    end

endmodule

`default_nettype wire

[tb/serial_power_command_decoder_tb.sv]
// serial_power_command_decoder_tb: stimulus, handshake idling and verdict for the
// serial power command decoder; prediction lives in spcd_status_check
// depends on spcd_pkg, spcd_cmd_if, spcd_status_if, spcd_cfg_if, spcd_status_check
`default_nettype none

module serial_power_command_decoder_tb;
    import spcd_pkg::*;

    localparam int unsigned DEPTH       = 19;
    localparam int          IDLE_LIMIT  = 3000;   // cycles with no handshake at all
    localparam int          HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int          DRAIN_WAIT  = 4;      // two pipeline stages plus margin

    logic clk;
    logic rst_n;

    spcd_cmd_if    cmd_ch ();
    spcd_status_if status_ch ();
    spcd_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int item_count;
    int on_count;
    int off_count;
    int timeout_count;

    // stimulus bookkeeping
    logic [7:0]  tx_frame [$];
    logic [15:0] cur_limit;
    int          items_sent;
    int          limit_writes;
    bit          send_burst;
    bit          fast_mode;      // both sides stop idling for long tick runs
    int          hold_req_count;
    int          hold_done_count;
    int          idle_cycles;

    serial_power_command_decoder #(.STORE_DEPTH(DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .status (status_ch),
        .cfg    (cfg_ch)
    );

    spcd_status_check #(.STORE_DEPTH(DEPTH)) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_ch.valid),
        .cmd_ready      (cmd_ch.ready),
        .cmd_kind       (cmd_ch.kind),
        .cmd_rx_byte    (cmd_ch.rx_byte),
        .cfg_valid      (cfg_ch.valid),
        .cfg_ready      (cfg_ch.ready),
        .cfg_data       (cfg_ch.data),
        .st_valid       (status_ch.valid),
        .st_ready       (status_ch.ready),
        .st_event_valid (status_ch.event_valid),
        .st_event_code  (status_ch.event_code),
        .st_power_on    (status_ch.power_on),
        .fail_count     (fail_count),
        .pending        (pending),
        .item_count     (item_count),
        .on_count       (on_count),
        .off_count      (off_count),
        .timeout_count  (timeout_count)
    );

    // clock, period 10
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one item, idle first for a random number of cycles, return on accept
    // valid stays high afterwards so back-to-back items need no extra assignment
    task automatic send_item(input spcd_kind_t k, input logic [7:0] b);
        int gap;
        gap = (fast_mode || send_burst) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.kind    <= k;
        cmd_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
    endtask

    // ticks carry a random byte, which the block must ignore
    task automatic send_ticks(input int n);
        repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    // send the staged frame, with a few ticks between bytes that stay under the limit
    task automatic send_frame(input int max_pause);
        for (int i = 0; i < tx_frame.size(); i++)
        begin
            send_item(KIND_BYTE, tx_frame[i]);
            if (max_pause > 0 && $urandom_range(0, 3) == 0)
                send_ticks(int'($urandom_range(0, max_pause)));
        end
    endtask

    task automatic load_command(input bit turn_on);
        tx_frame.delete();
        for (int i = 0; i < PREFIX_LEN; i++)
            tx_frame.push_back(CMD_PREFIX[i]);
        tx_frame.push_back(turn_on ? BYTE_00 : BYTE_01);
        tx_frame.push_back(turn_on ? BYTE_01 : BYTE_11);
        tx_frame.push_back(BYTE_SYNC);
    endtask

    task automatic load_start();
        tx_frame.delete();
        for (int i = 0; i < START_FRAME_LEN; i++)
            tx_frame.push_back(START_FRAME[i]);
    endtask

    // flip some bits of one byte, hitting the prefix, the tail or the start frame
    task automatic corrupt_frame();
        int         idx;
        logic [7:0] flip;
        idx  = int'($urandom_range(0, tx_frame.size() - 1));
        flip = 8'($urandom_range(1, 255));
        tx_frame[idx] = tx_frame[idx] ^ flip;
    endtask

    // stage one of the three frame kinds
    task automatic load_any();
        case ($urandom_range(0, 2))
            0: load_command(1'b1);
            1: load_command(1'b0);
            default: load_start();
        endcase
    endtask

    // enough ticks to empty the store and stop the timer (limit is small here)
    task automatic flush_store();
        send_ticks(int'(cur_limit) + int'($urandom_range(0, 2)));
    endtask

    // wait until every status item has come, then let the pipeline settle
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic write_limit(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_limit = value;
        limit_writes++;
    endtask

    // one byte to start the timer, then a run of ticks without idling
    task automatic timeout_run(input int n);
        fast_mode = 1'b1;
        send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        send_ticks(n + 1);
        fast_mode = 1'b0;
    endtask

    // mostly well-formed frames picked at random, the rest noise, tick bursts and broken frames
    task automatic run_random(input int target);
        int stop_at;
        int pause;
        int n;
        stop_at = items_sent + target;
        pause   = (cur_limit > 1) ? ((cur_limit - 1 > 40) ? 40 : cur_limit - 1) : 0;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // power on command from an empty store, sometimes broken
                    flush_store();
                    load_command(1'b1);
                    if ($urandom_range(0, 3) == 0)
                        corrupt_frame();
                    send_frame(pause);
                end
                2, 3:
                begin
                    // power off command from an empty store, sometimes broken
                    flush_store();
                    load_command(1'b0);
                    if ($urandom_range(0, 3) == 0)
                        corrupt_frame();
                    send_frame(pause);
                end
                4:
                begin
                    // start frame, sometimes broken (store empties at 19 anyway)
                    flush_store();
                    load_start();
                    if ($urandom_range(0, 2) == 0)
                        corrupt_frame();
                    send_frame(pause);
                end
                5:
                begin
                    // frame on top of whatever the store holds
                    load_any();
                    send_frame(pause);
                end
                6:
                begin
                    // plain noise bytes
                    n = int'($urandom_range(1, 20));
                    repeat (n) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
                end
                7:
                begin
                    // tick burst, may or may not reach the limit
                    send_ticks(int'($urandom_range(1, int'(cur_limit) + 3)));
                end
                8:
                begin
                    // noise built from frame bytes, likely to get part way into a match
                    n = int'($urandom_range(1, 20));
                    repeat (n)
                    begin
                        case ($urandom_range(0, 4))
                            0: send_item(KIND_BYTE, BYTE_00);
                            1: send_item(KIND_BYTE, BYTE_01);
                            2: send_item(KIND_BYTE, BYTE_11);
                            3: send_item(KIND_BYTE, BYTE_SYNC);
                            default: send_item(KIND_BYTE, 8'h02);
                        endcase
                    end
                end
                default:
                begin
                    // partial frame discarded by a timeout
                    flush_store();
                    load_any();
                    n = int'($urandom_range(1, tx_frame.size() - 1));
                    while (tx_frame.size() > n)
                        void'(tx_frame.pop_back());
                    send_frame(pause);
                    flush_store();
                end
            endcase
        end
    endtask

    // status receiver: random ready gaps, bursts without gaps, one long hold-off
    initial
    begin
        int gap;
        bit recv_burst;
        int hold_cycles;
        recv_burst = 1'b0;
        status_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req_count > hold_done_count)
            begin
                // hold off long enough that the block fills and stalls cmd
                status_ch.ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_done_count++;
            end else
            begin
                gap = (fast_mode || recv_burst) ? 0 : $urandom_range(0, 13);
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                if (gap > 0)
                begin
                    status_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            status_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!status_ch.valid);
        end
    end

    // watchdog: counts cycles in which no channel moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("serial_power_command_decoder test failed");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // main sequence
    initial
    begin
        cmd_ch.valid    <= 1'b0;
        cmd_ch.kind     <= KIND_BYTE;
        cmd_ch.rx_byte  <= 8'h00;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= TIMEOUT_RESET;
        rst_n           <= 1'b0;
        cur_limit       = TIMEOUT_RESET;
        items_sent      = 0;
        limit_writes    = 0;
        send_burst      = 1'b0;
        fast_mode       = 1'b0;
        hold_req_count  = 0;
        hold_done_count = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick with the timer stopped, a power on command,
        // byte extremes, then a tick run that stays under the reset limit of 1000
        send_item(KIND_TICK, 8'hff);
        load_command(1'b1);
        send_frame(0);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_BYTE, 8'h00);
        timeout_run(30);
        wait_drained();

        // smallest nonzero limit: the first tick after a byte is a timeout
        write_limit(16'd1);
        load_command(1'b0);
        send_frame(0);
        load_start();
        send_frame(0);
        run_random(230);
        wait_drained();

        // small random limits, the first phase with the long receiver hold-off
        for (int p = 0; p < 3; p++)
        begin
            write_limit(16'($urandom_range(2, 40)));
            if (p == 0)
                hold_req_count++;
            run_random(280);
            wait_drained();
        end

        // largest limit, then zero, each with a short tick run that raises no timeout
        write_limit(16'hffff);
        timeout_run(20);
        wait_drained();
        write_limit(16'h0000);
        timeout_run(20);
        wait_drained();

        $display("covered %0d items over %0d limit settings:", item_count, limit_writes + 1);
        $display("  %0d power on, %0d power off, %0d timeout events",
                 on_count, off_count, timeout_count);
        if (fail_count == 0 && pending == 0)
            $display("serial_power_command_decoder test passed");
        else
            $display("serial_power_command_decoder test failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/spcd_pkg.sv
sv/spcd_cmd_if.sv
sv/spcd_status_if.sv
sv/spcd_cfg_if.sv
sv/serial_power_command_decoder.sv
tb/spcd_status_check.sv
tb/serial_power_command_decoder_tb.sv
